/* sv/ssbd_pkg.sv */
// shared types, constants and rotate helpers for the speck-style block decrypt core
`timescale 1ns / 1ps

package ssbd_pkg;

  localparam int unsigned WordW        = 16;
  localparam int unsigned NumRounds    = 4;
  localparam int unsigned AlphaRot     = 7;
  localparam int unsigned BetaRot      = 2;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned SettleCycles = NumRounds;
  localparam int unsigned SettleW      = $clog2(SettleCycles + 1);

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_WORD0 = 2'd0,
    REG_KEY_WORD1 = 2'd1,
    REG_KEY_WORD2 = 2'd2,
    REG_KEY_WORD3 = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    word_t cipher_x;
    word_t cipher_y;
  } in_t;

  typedef struct packed {
    word_t plain_x;
    word_t plain_y;
  } out_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } blk_t;

  typedef word_t [NumRounds-1:0] rkeys_t;

  typedef struct packed {
    logic settling;
  } key_status_t;

  function automatic word_t ror_w(input word_t v, input int unsigned s);
    return (v >> s) | (v << (WordW - s));
  endfunction

  function automatic word_t rol_w(input word_t v, input int unsigned s);
    return (v << s) | (v >> (WordW - s));
  endfunction

endpackage

/* sv/ssbd_key_sched.sv */
// key word registers and the registered round key schedule
`timescale 1ns / 1ps

module ssbd_key_sched
  import ssbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  word_t              cfg_wdata_i,
  output rkeys_t             rkeys_o,
  output key_status_t        status_o
);

  word_t [NumRounds-1:0] kw_q;
  word_t [NumRounds-1:0] rk_q;
  word_t [NumRounds-1:0] rk_d;
  logic [SettleW-1:0]    settle_q;
  logic [SettleW-1:0]    settle_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_WORD0: kw_q[0] <= cfg_wdata_i;
        REG_KEY_WORD1: kw_q[1] <= cfg_wdata_i;
        REG_KEY_WORD2: kw_q[2] <= cfg_wdata_i;
        REG_KEY_WORD3: kw_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // one schedule step per cycle
  assign rk_d[0] = kw_q[0];
  for (genvar i = 1; i < NumRounds; i++) begin : g_sched
    assign rk_d[i] = (ror_w(rk_q[i-1], AlphaRot) + kw_q[i]) ^ WordW'(i - 1);
  end

  always_ff @(posedge clk_i) begin
    rk_q <= rk_d;
  end

  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = SettleW'(SettleCycles);
    end else if (settle_q != '0) begin
      settle_d = settle_q - SettleW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleW'(SettleCycles);
    end else begin
      settle_q <= settle_d;
    end
  end

  assign rkeys_o[0] = kw_q[0];
  for (genvar i = 1; i < NumRounds; i++) begin : g_out
    assign rkeys_o[i] = rk_q[i];
  end

  assign status_o.settling = cfg_we_i || (settle_q != '0);

endmodule

/* sv/ssbd_round.sv */
// one registered inverse round stage
`timescale 1ns / 1ps

module ssbd_round
  import ssbd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  blk_t  blk_i,
  input  word_t key_i,
  output logic  valid_o,
  output blk_t  blk_o
);

  logic  valid_q;
  blk_t  blk_q;
  blk_t  blk_d;

  always_comb begin
    blk_d.y = ror_w(blk_i.x ^ blk_i.y, BetaRot);
    blk_d.x = rol_w((blk_i.x ^ key_i) - blk_d.y, AlphaRot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

/* sv/speck_style_block_decrypt_core.sv */
// top level of the four-round speck-style block decrypt core
`timescale 1ns / 1ps

// Decrypts one 32-bit block (two 16-bit words) per request through four
// pipelined inverse rounds, one register stage per round. A request is taken
// when start_i is high and busy_o is low; the plaintext appears on result_o
// with done_o high for one cycle, in request order.
// A new request can be taken every cycle while busy_o is low. The receiver
// cannot stall the output. Round keys come from a registered schedule that
// settles after reset or after a key write; busy_o is high while it settles
// and in the cycle of a key write. Keys must only be written while no
// request is in flight.

module speck_style_block_decrypt_core
  import ssbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  in_t                req_i,
  output logic               done_o,
  output out_t               result_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  word_t              cfg_wdata_i
);

  rkeys_t      rkeys;
  key_status_t key_status;
  logic        accept;
  logic [NumRounds:0] valid;
  blk_t [NumRounds:0] blk;

  ssbd_key_sched u_key_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rkeys_o     (rkeys),
    .status_o    (key_status)
  );

  assign busy_o = key_status.settling;
  assign accept = start_i && !busy_o;

  assign valid[0]  = accept;
  assign blk[0].x  = req_i.cipher_x;
  assign blk[0].y  = req_i.cipher_y;

  // last round key first
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    ssbd_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[r]),
      .blk_i   (blk[r]),
      .key_i   (rkeys[NumRounds-1-r]),
      .valid_o (valid[r+1]),
      .blk_o   (blk[r+1])
    );
  end

  assign done_o           = valid[NumRounds];
  assign result_o.plain_x = blk[NumRounds].x;
  assign result_o.plain_y = blk[NumRounds].y;

`ifndef SYNTH
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##3 done_o)
    else $error("request did not complete after four cycles");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result without a matching request");

  a_write_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o)
    else $error("key write not followed by busy");

  a_keys_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> $stable(rkeys))
    else $error("round keys changed while requests are accepted");
`endif

endmodule

/* sim/tb_top.sv */
// testbench for speck_style_block_decrypt_core: random and directed blocks checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import ssbd_pkg::*;

  typedef struct {
    in_t         blk;
    int unsigned gap;
  } cipher_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  in_t                req_i = '0;
  logic               done_o;
  out_t               result_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  word_t              cfg_wdata_i = '0;

  cipher_req_t cipher_q [$];
  out_t        plain_q [$];
  word_t       key_mem [NumRounds] = '{default: '0};
  cipher_req_t nxt;
  bit          have_next = 1'b0;
  logic        req_taken = 1'b0;
  int unsigned n_sent = 0;
  int unsigned n_accepted = 0;
  int unsigned n_fail = 0;

  speck_style_block_decrypt_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic word_t ror16(input word_t v, input int unsigned s);
    logic [2*WordW-1:0] t;
    t = {v, v} >> s;
    return t[WordW-1:0];
  endfunction

  function automatic word_t rol16(input word_t v, input int unsigned s);
    logic [2*WordW-1:0] t;
    t = {v, v} << s;
    return t[2*WordW-1:WordW];
  endfunction

  function automatic out_t decrypt_block(input in_t c);
    word_t rk [NumRounds];
    word_t x;
    word_t y;
    word_t diff;
    out_t  p;
    rk[0] = key_mem[0];
    for (int i = 1; i < NumRounds; i++) begin
      rk[i] = (ror16(rk[i-1], AlphaRot) + key_mem[i]) ^ word_t'(i - 1);
    end
    x = c.cipher_x;
    y = c.cipher_y;
    for (int r = NumRounds - 1; r >= 0; r--) begin
      y    = ror16(x ^ y, BetaRot);
      diff = (x ^ rk[r]) - y;
      x    = rol16(diff, AlphaRot);
    end
    p.plain_x = x;
    p.plain_y = y;
    return p;
  endfunction

  function automatic word_t pick_word();
    int unsigned k;
    k = $urandom_range(0, WordW - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << k;
      3: return ~(word_t'(1) << k);
      default: return word_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic int unsigned pick_gap(input int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  task automatic push_block(input word_t x, input word_t y, input int unsigned gap);
    cipher_req_t r;
    r.blk.cipher_x = x;
    r.blk.cipher_y = y;
    r.gap          = gap;
    cipher_q.push_back(r);
    n_sent++;
  endtask

  task automatic write_key(input cfg_reg_e idx, input word_t val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    key_mem[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (cipher_q.size() != 0 || have_next || n_accepted != n_sent || plain_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start_i || req_taken) begin
        if (!have_next && cipher_q.size() > 0) begin
          nxt       = cipher_q.pop_front();
          have_next = 1'b1;
        end
        if (have_next && nxt.gap == 0) begin
          start_i   <= 1'b1;
          req_i     <= nxt.blk;
          have_next = 1'b0;
        end else begin
          start_i <= 1'b0;
          if (have_next) begin
            nxt.gap--;
          end
        end
      end
    end
  end

  // result monitor and request capture
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni) begin
      if (done_o) begin
        if (plain_q.size() == 0) begin
          $error("unexpected result x=%h y=%h", result_o.plain_x, result_o.plain_y);
          n_fail++;
        end else begin
          e = plain_q.pop_front();
          if (result_o.plain_x !== e.plain_x) begin
            $error("plain_x expected %h actual %h", e.plain_x, result_o.plain_x);
            n_fail++;
          end
          if (result_o.plain_y !== e.plain_y) begin
            $error("plain_y expected %h actual %h", e.plain_y, result_o.plain_y);
            n_fail++;
          end
        end
      end
      req_taken <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        plain_q.push_back(decrypt_block(req_i));
        n_accepted++;
      end
    end else begin
      req_taken <= 1'b0;
    end
  end

  initial begin
    word_t keys [NumRounds];
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed blocks under reset keys
    @(posedge clk_i);
    push_block(16'h0000, 16'h0000, 0);
    push_block(16'hFFFF, 16'hFFFF, 0);
    push_block(16'h0000, 16'hFFFF, 0);
    push_block(16'hFFFF, 16'h0000, 1);
    push_block(16'h8000, 16'h8000, 0);
    push_block(16'h0001, 16'h0001, 0);
    push_block(16'h8000, 16'h0000, 3);
    push_block(16'h0000, 16'h8000, 0);
    push_block(16'hAAAA, 16'h5555, 0);
    push_block(16'h5555, 16'hAAAA, 0);
    push_block(16'h0001, 16'hFFFF, 2);
    push_block(16'hFFFF, 16'h0001, 0);
    push_block(16'h7FFF, 16'h8000, 0);
    push_block(16'h1234, 16'hFEDC, 0);
    push_block(16'h0100, 16'h0080, 5);
    push_block(16'hFFFE, 16'h7FFF, 0);
    drain();

    for (int p = 0; p < 10; p++) begin
      for (int i = 0; i < NumRounds; i++) begin
        case (p)
          0: keys[i] = '1;
          1: keys[i] = '0;
          2: keys[i] = (i % 2 == 0) ? 16'h8000 : 16'hFFFF;
          3: keys[i] = (i % 2 == 0) ? 16'h0001 : 16'h7FFF;
          default: keys[i] = word_t'($urandom_range(0, 16'hFFFF));
        endcase
      end
      for (int i = 0; i < NumRounds; i++) begin
        write_key(cfg_reg_e'(i), keys[i]);
      end
      @(posedge clk_i);
      for (int n = 0; n < 103; n++) begin
        push_block(pick_word(), pick_word(), pick_gap(p % 3));
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("[speck_style_block_decrypt_core] OK");
    end else begin
      $display("[speck_style_block_decrypt_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[speck_style_block_decrypt_core] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
sv/ssbd_pkg.sv
sv/ssbd_key_sched.sv
sv/ssbd_round.sv
sv/speck_style_block_decrypt_core.sv
sim/tb_top.sv
